// ===== hdl/rdtq_pkg.sv =====
package rdtq_pkg;

    localparam int MAX_TIMERS = 16;
    localparam int IDX_W      = $clog2(MAX_TIMERS);
    localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
    localparam int DELTA_W    = 16;
    localparam int SEQ_W      = 8;
    localparam int FUNC_W     = 3;
    localparam int KIND_W     = 2;

    localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_START_DATA = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_START_ACK  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_STOP_DATA  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_STOP_ACK   = 3'd4;

    localparam logic [KIND_W-1:0] EVT_NONE = 2'd0;
    localparam logic [KIND_W-1:0] EVT_DATA = 2'd1;
    localparam logic [KIND_W-1:0] EVT_ACK  = 2'd2;

    localparam logic [DELTA_W-1:0] TIMEOUT_RESET = 16'd1000;

    // One timer entry held by a cell.
    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic               is_ack;
        logic [SEQ_W-1:0]   seq;
    } t_entry;

    // Broadcast to every cell.
    typedef struct packed {
        logic             pop;       // shift the whole row down by one
        logic             stop;      // search and remove first match
        logic             stop_ack;  // match any ack entry
        logic [SEQ_W-1:0] key;       // sequence to match on stop data
    } t_cmd;

    // Per-cell strobes.
    typedef struct packed {
        logic load;
        logic dec;
    } t_cell_ctl;

    // Search status handed along the row.
    typedef struct packed {
        logic found;
        logic first;
    } t_scan;

endpackage

// ===== hdl/retransmit_delta_timer_queue.sv =====
// A result is registered and appears in the cycle after its item is transferred in.
// Throughput: one item per cycle while the result register is free or draining;
// the whole row of timer cells updates together, so tick, start and stop each act at once.
// Reset (synchronous, active low): empties the list, clears the pending total,
// drops the result valid, and sets timeout_ticks to 1000. Cell contents are
// not reset; only cells below the live count are ever read.
module retransmit_delta_timer_queue
    import rdtq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [SEQ_W-1:0]   i_seq,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [KIND_W-1:0]  o_event_kind,
    output logic [SEQ_W-1:0]   o_timeout_seq,
    output logic               o_full_drop,
    // timeout_ticks write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [DELTA_W-1:0] i_cfg_data
);

    // Control and configuration registers
    logic [DELTA_W-1:0] r_timeout_ticks;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [DELTA_W-1:0] r_pending;
    logic [DELTA_W-1:0] n_pending;

    // Result register
    logic               r_out_valid;
    logic [KIND_W-1:0]  r_event_kind;
    logic [KIND_W-1:0]  n_event_kind;
    logic [SEQ_W-1:0]   r_timeout_seq;
    logic [SEQ_W-1:0]   n_timeout_seq;
    logic               r_full_drop;
    logic               n_full_drop;

    // Cell row wiring
    t_entry    w_entry [MAX_TIMERS];
    t_scan     w_scan  [MAX_TIMERS];
    t_cell_ctl w_ctl   [MAX_TIMERS];
    logic      w_live  [MAX_TIMERS];
    t_cmd      cmd;
    t_entry    new_entry;

    logic               accept;
    logic               empty;
    logic               full;
    logic [IDX_W-1:0]   tail_idx;
    logic [IDX_W-1:0]   load_idx;
    logic               head_dec;
    logic               do_load;
    logic [DELTA_W-1:0] start_delta;
    logic [DELTA_W-1:0] room;
    logic [DELTA_W-1:0] tail_delta;

    // Accept a new item whenever the result register is free or draining.
    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    assign empty    = (r_count == '0);
    assign full     = (r_count == CNT_W'(MAX_TIMERS));
    assign tail_idx = IDX_W'(r_count - CNT_W'(1));
    assign load_idx = r_count[IDX_W-1:0];
    assign tail_delta = w_entry[tail_idx].delta;

    // Delta for a new timer: limit minus total, at least 1, then capped so the
    // total stays within 16 bits, which can bring it down to 0.
    always_comb begin
        room = '1 - r_pending;
        if (r_timeout_ticks > r_pending) begin
            start_delta = r_timeout_ticks - r_pending;
        end else begin
            start_delta = DELTA_W'(1);
        end
        if (start_delta > room) begin
            start_delta = room;
        end
    end

    // Broadcast command for the row; a tick pops only when the head expires.
    always_comb begin
        cmd          = '0;
        cmd.key      = i_seq;
        cmd.stop_ack = (i_func == FUNC_STOP_ACK);
        cmd.stop     = accept && (i_func inside {FUNC_STOP_DATA, FUNC_STOP_ACK});
        cmd.pop      = accept && (i_func == FUNC_TICK) && !empty
                       && (w_entry[0].delta[DELTA_W-1:1] == '0);
    end

    always_comb begin
        head_dec      = 1'b0;
        do_load       = 1'b0;
        new_entry.delta  = start_delta;
        new_entry.is_ack = (i_func == FUNC_START_ACK);
        new_entry.seq    = (i_func == FUNC_START_ACK) ? '0 : i_seq;
        n_count       = r_count;
        n_pending     = r_pending;
        n_event_kind  = EVT_NONE;
        n_timeout_seq = '0;
        n_full_drop   = 1'b0;

        if (accept) begin
            case (i_func)
                FUNC_TICK: begin
                    if (!empty) begin
                        if (w_entry[0].delta != '0 && r_pending != '0) begin
                            n_pending = r_pending - DELTA_W'(1);
                        end
                        if (w_entry[0].delta[DELTA_W-1:1] == '0) begin
                            // Head expires: report it and advance the row.
                            n_count = r_count - CNT_W'(1);
                            if (w_entry[0].is_ack) begin
                                n_event_kind = EVT_ACK;
                            end else begin
                                n_event_kind  = EVT_DATA;
                                n_timeout_seq = w_entry[0].seq;
                            end
                        end else begin
                            head_dec = 1'b1;
                        end
                    end
                end
                FUNC_START_DATA, FUNC_START_ACK: begin
                    if (full) begin
                        n_full_drop = 1'b1;
                    end else begin
                        do_load   = 1'b1;
                        n_count   = r_count + CNT_W'(1);
                        n_pending = r_pending + start_delta;
                    end
                end
                FUNC_STOP_DATA, FUNC_STOP_ACK: begin
                    // Stop outcome comes back from the search chain along the row.
                    if (w_scan[MAX_TIMERS-1].found) begin
                        n_count = r_count - CNT_W'(1);
                        if (w_scan[tail_idx].first) begin
                            // Removed the tail: drop its delta from the total.
                            n_pending = (r_pending >= tail_delta) ? r_pending - tail_delta : '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TIMERS; gi++) begin : g_cell
            assign w_live[gi]     = (CNT_W'(gi) < r_count);
            assign w_ctl[gi].load = do_load && (load_idx == IDX_W'(gi));
            assign w_ctl[gi].dec  = (gi == 0) ? head_dec : 1'b0;

            if (gi == MAX_TIMERS - 1) begin : g_last
                rdtq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_cmd        (cmd),
                    .i_ctl        (w_ctl[gi]),
                    .i_live       (w_live[gi]),
                    .i_new        (new_entry),
                    .i_next       ('0),
                    .i_found_prev (w_scan[gi-1].found),
                    .o_entry      (w_entry[gi]),
                    .o_scan       (w_scan[gi])
                );
            end else if (gi == 0) begin : g_head
                rdtq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_cmd        (cmd),
                    .i_ctl        (w_ctl[gi]),
                    .i_live       (w_live[gi]),
                    .i_new        (new_entry),
                    .i_next       (w_entry[gi+1]),
                    .i_found_prev (1'b0),
                    .o_entry      (w_entry[gi]),
                    .o_scan       (w_scan[gi])
                );
            end else begin : g_mid
                rdtq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_cmd        (cmd),
                    .i_ctl        (w_ctl[gi]),
                    .i_live       (w_live[gi]),
                    .i_new        (new_entry),
                    .i_next       (w_entry[gi+1]),
                    .i_found_prev (w_scan[gi-1].found),
                    .o_entry      (w_entry[gi]),
                    .o_scan       (w_scan[gi])
                );
            end
        end
    endgenerate

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TIMEOUT_RESET;
            r_count         <= '0;
            r_pending       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout_ticks <= i_cfg_data;
            end
            r_count   <= n_count;
            r_pending <= n_pending;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result until it is transferred out.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_event_kind  <= n_event_kind;
            r_timeout_seq <= n_timeout_seq;
            r_full_drop   <= n_full_drop;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_event_kind;
    assign o_timeout_seq = r_timeout_seq;
    assign o_full_drop   = r_full_drop;

endmodule

// ===== hdl/rdtq_cell.sv =====
module rdtq_cell
    import rdtq_pkg::*;
(
    input  logic      i_clk,
    input  t_cmd      i_cmd,
    input  t_cell_ctl i_ctl,
    input  logic      i_live,
    input  t_entry    i_new,
    input  t_entry    i_next,
    input  logic      i_found_prev,
    output t_entry    o_entry,
    output t_scan     o_scan
);

    t_entry           r_entry;
    t_entry           n_entry;
    logic             hit;
    logic [DELTA_W:0] merge_sum;

    always_comb begin
        hit = i_live && i_cmd.stop &&
              (i_cmd.stop_ack ? r_entry.is_ack
                              : (!r_entry.is_ack && (r_entry.seq == i_cmd.key)));
        o_scan.first = hit && !i_found_prev;
        o_scan.found = hit || i_found_prev;
        merge_sum    = {1'b0, i_next.delta} + {1'b0, r_entry.delta};
    end

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load) begin
            n_entry = i_new;
        end else if (i_cmd.pop) begin
            n_entry = i_next;
        end else if (i_ctl.dec) begin
            n_entry.delta = r_entry.delta - DELTA_W'(1);
        end else if (i_cmd.stop && o_scan.found) begin
            // Pull the successor in; the removed cell folds its delta into it.
            n_entry = i_next;
            if (o_scan.first) begin
                n_entry.delta = merge_sum[DELTA_W] ? '1 : merge_sum[DELTA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== hdl/rdtq_checker.sv =====
module rdtq_checker
    import rdtq_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [KIND_W-1:0]  o_event_kind,
    input logic [SEQ_W-1:0]   o_timeout_seq,
    input logic               o_full_drop
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_event_kind)
            && $stable(o_timeout_seq) && $stable(o_full_drop))
        else $error("result changed while stalled");

    // Every transferred item yields a result on the next cycle.
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("no result after item transfer");

    // Block new items while a result waits.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("item taken while result stalled");

    // A timeout and a dropped start never come from the same item.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind != EVT_NONE |-> !o_full_drop)
        else $error("timeout reported with full drop");

    // Only data timeouts carry a sequence.
    a_seq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind != EVT_DATA |-> o_timeout_seq == '0)
        else $error("sequence on non-data result");

endmodule

bind retransmit_delta_timer_queue rdtq_checker u_rdtq_checker (.*);

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rdtq_pkg::*;

    // Func codes the block leaves unused; they must report no event.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    localparam int DELTA_MAX      = (1 << DELTA_W) - 1;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int ITEMS_PER_SEG  = 250;
    localparam int NUM_SEGS       = 6;

    // One result transfer as the block reports it.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  tseq;
        logic              drop;
    } t_outcome;

    localparam t_outcome QUIET   = '{EVT_NONE, 8'h00, 1'b0};
    localparam t_outcome DROPPED = '{EVT_NONE, 8'h00, 1'b1};

    // A directed row either sends an item (repeated reps times, seq stepping
    // by one per repeat) or writes timeout_ticks. Rows with pin set carry the
    // event typed in by hand; the rest are checked against the predictor.
    typedef enum logic {ROW_OP, ROW_LIMIT} t_row_kind;

    typedef struct packed {
        t_row_kind         what;
        logic [FUNC_W-1:0] func;
        logic [DELTA_W-1:0] arg;
        logic [DELTA_W-1:0] reps;
        logic              pin;
        t_outcome          want;
    } t_row;

    localparam int NUM_ROWS = 31;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        // reset limit of 1000, empty list, unused codes, stops that miss
        '{ROW_OP,    FUNC_TICK,       16'h0000, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_SPARE_LO,   16'h0000, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_SPARE_HI,   16'h00FF, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_STOP_DATA,  16'h0000, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_STOP_ACK,   16'h0000, 16'd1,     1'b1, QUIET},
        // second start sees limit equal to the total and gets delta 1
        '{ROW_OP,    FUNC_START_DATA, 16'h00FF, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_START_ACK,  16'h0000, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_STOP_DATA,  16'h0000, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_STOP_DATA,  16'h00FF, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_STOP_ACK,   16'h0000, 16'd1,     1'b1, QUIET},
        // zero limit still gives delta 1
        '{ROW_LIMIT, FUNC_TICK,       16'd0,    16'd1,     1'b0, QUIET},
        '{ROW_OP,    FUNC_START_DATA, 16'h005A, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_TICK,       16'h0000, 16'd1,     1'b1, '{EVT_DATA, 8'h5A, 1'b0}},
        '{ROW_LIMIT, FUNC_TICK,       16'd1,    16'd1,     1'b0, QUIET},
        '{ROW_OP,    FUNC_START_ACK,  16'h0000, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_TICK,       16'h0000, 16'd1,     1'b1, '{EVT_ACK, 8'h00, 1'b0}},
        // fill the list, bounce two starts off it, then drain it
        '{ROW_OP,    FUNC_START_DATA, 16'h0000, 16'd16,    1'b0, QUIET},
        '{ROW_OP,    FUNC_START_ACK,  16'h0000, 16'd1,     1'b1, DROPPED},
        '{ROW_OP,    FUNC_START_DATA, 16'h0080, 16'd1,     1'b1, DROPPED},
        '{ROW_OP,    FUNC_TICK,       16'h0000, 16'd16,    1'b0, QUIET},
        // push the total to its ceiling so that the last two starts get delta 0
        '{ROW_OP,    FUNC_START_DATA, 16'h0011, 16'd1,     1'b1, QUIET},
        '{ROW_LIMIT, FUNC_TICK,       16'hFFFF, 16'd1,     1'b0, QUIET},
        '{ROW_OP,    FUNC_START_DATA, 16'h0022, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_START_ACK,  16'h0000, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_START_DATA, 16'h0033, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_TICK,       16'h0000, 16'd1,     1'b1, '{EVT_DATA, 8'h11, 1'b0}},
        // remove the big timer, fold its delta down the list, then empty it
        '{ROW_OP,    FUNC_STOP_DATA,  16'h0022, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_TICK,       16'h0000, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_STOP_ACK,   16'h0000, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_STOP_DATA,  16'h0033, 16'd1,     1'b1, QUIET},
        '{ROW_OP,    FUNC_TICK,       16'h0000, 16'd1,     1'b1, QUIET}
    };

    // Limits for the random segments; one segment draws its own.
    localparam int SEG_LIMIT [NUM_SEGS] = '{4, 1, 25, 2, 0, 9};
    localparam int RANDOM_LIMIT_SEG = 4;

    // ------------------------------------------------------------------
    // DUT signals: every input is known from time zero.
    // ------------------------------------------------------------------
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [FUNC_W-1:0]  i_func      = FUNC_TICK;
    logic [SEQ_W-1:0]   i_seq       = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [KIND_W-1:0]  o_event_kind;
    logic [SEQ_W-1:0]   o_timeout_seq;
    logic               o_full_drop;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [DELTA_W-1:0] i_cfg_data  = '0;

    retransmit_delta_timer_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_seq         (i_seq),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_kind  (o_event_kind),
        .o_timeout_seq (o_timeout_seq),
        .o_full_drop   (o_full_drop),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the delta list and the limit.
    // ------------------------------------------------------------------
    int   timer_delta [MAX_TIMERS];
    bit   timer_is_ack [MAX_TIMERS];
    logic [SEQ_W-1:0] timer_seq [MAX_TIMERS];
    int   live_count    = 0;
    int   ticks_pending = 0;
    int   limit_ticks   = int'(TIMEOUT_RESET);

    t_outcome pending_events [$];   // events owed by the block, oldest first
    bit       pin_typed = 1'b0;     // the item on the bus has a hand-typed event
    t_outcome typed_event = QUIET;
    int       mismatches = 0;
    int       stall_cycles = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    // Close the gap left by a removed timer.
    function automatic void drop_timer(input int pos);
        int i;
        for (i = pos; i + 1 < live_count; i++) begin
            timer_delta[i]  = timer_delta[i + 1];
            timer_is_ack[i] = timer_is_ack[i + 1];
            timer_seq[i]    = timer_seq[i + 1];
        end
        live_count--;
    endfunction

    // Apply one operation to the delta list and return the event it reports.
    function automatic t_outcome next_timer_event(input logic [FUNC_W-1:0] f,
                                                  input logic [SEQ_W-1:0] s);
        t_outcome ev;
        int d;
        int pos;
        int i;
        ev = QUIET;
        case (f)
            FUNC_TICK: begin
                if (live_count > 0) begin
                    d = timer_delta[0];
                    // a delta-0 head expires without consuming a tick
                    if (d > 0 && ticks_pending > 0)
                        ticks_pending--;
                    if (d <= 1) begin
                        ev.kind = timer_is_ack[0] ? EVT_ACK : EVT_DATA;
                        ev.tseq = timer_is_ack[0] ? '0 : timer_seq[0];
                        drop_timer(0);
                    end else begin
                        timer_delta[0] = d - 1;
                    end
                end
            end
            FUNC_START_DATA, FUNC_START_ACK: begin
                if (live_count >= MAX_TIMERS) begin
                    ev.drop = 1'b1;
                end else begin
                    // append behind the pending total; clamp at the ceiling
                    d = (limit_ticks > ticks_pending) ? limit_ticks - ticks_pending : 1;
                    if (d > DELTA_MAX - ticks_pending)
                        d = DELTA_MAX - ticks_pending;
                    timer_delta[live_count]  = d;
                    timer_is_ack[live_count] = (f == FUNC_START_ACK);
                    timer_seq[live_count]    = (f == FUNC_START_ACK) ? '0 : s;
                    live_count++;
                    ticks_pending += d;
                end
            end
            FUNC_STOP_DATA, FUNC_STOP_ACK: begin
                pos = -1;
                for (i = 0; i < live_count && pos < 0; i++) begin
                    if (f == FUNC_STOP_ACK ? timer_is_ack[i]
                                           : (!timer_is_ack[i] && timer_seq[i] == s))
                        pos = i;
                end
                if (pos >= 0) begin
                    d = timer_delta[pos];
                    // hand the removed delta to the successor, or shrink the total
                    if (pos + 1 < live_count)
                        timer_delta[pos + 1] = (timer_delta[pos + 1] + d > DELTA_MAX)
                                               ? DELTA_MAX : timer_delta[pos + 1] + d;
                    else
                        ticks_pending = (ticks_pending >= d) ? ticks_pending - d : 0;
                    drop_timer(pos);
                end
            end
            default: ;
        endcase
        return ev;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample at the rising edge, check results against the oldest
    // owed event, advance the predictor on every item transfer.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_outcome want;
        t_outcome ev;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_events.size() == 0) begin
                    report_mismatch("result with nothing owed", 16'(o_event_kind), 16'h0);
                end else begin
                    want = pending_events.pop_front();
                    if (o_event_kind !== want.kind)
                        report_mismatch("event_kind", 16'(o_event_kind), 16'(want.kind));
                    if (o_timeout_seq !== want.tseq)
                        report_mismatch("timeout_seq", 16'(o_timeout_seq), 16'(want.tseq));
                    if (o_full_drop !== want.drop)
                        report_mismatch("full_drop", 16'(o_full_drop), 16'(want.drop));
                end
            end
            if (i_in_valid && o_in_ready) begin
                // advance the predictor even when the row pins the event
                ev = next_timer_event(i_func, i_seq);
                pending_events.push_back(pin_typed ? typed_event : ev);
            end
            if (i_cfg_valid && o_cfg_ready)
                limit_ticks = int'(i_cfg_data);

            // Hold a count of cycles with no transfer on any channel.
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $realtime, stall_cycles);
                $display("** retransmit_delta_timer_queue: FAILED **");
                $finish;
            end
        end
    end

    // Result side: drop ready at random, at the falling edge.
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Present one item and hold it until the transfer. Idle first at random;
    // the drop and the raise of valid never share a time step.
    task automatic send_op(input logic [FUNC_W-1:0] f, input logic [SEQ_W-1:0] s,
                           input bit pin, input t_outcome want);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_func      <= f;
        i_seq       <= s;
        pin_typed   <= pin;
        typed_event <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Write timeout_ticks once the block has gone quiet.
    task automatic write_limit(input logic [DELTA_W-1:0] v);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random traffic: mostly start/tick/stop on live timers, with bursts of
    // starts that fill the list and a sprinkle of unused codes.
    task automatic run_random(input int n);
        int made;
        int burst;
        int r;
        int live_data;
        int pick;
        int i;
        logic [FUNC_W-1:0] f;
        logic [SEQ_W-1:0]  s;
        burst = 0;
        for (made = 0; made < n; made++) begin
            r = $urandom_range(99);
            if (burst == 0 && $urandom_range(39) == 0)
                burst = $urandom_range(20, 8);
            if (burst > 0) begin
                burst--;
                f = (r < 80) ? FUNC_START_DATA : FUNC_START_ACK;
            end else if (r < 40) begin
                f = FUNC_TICK;
            end else if (r < 62) begin
                f = FUNC_START_DATA;
            end else if (r < 70) begin
                f = FUNC_START_ACK;
            end else if (r < 85) begin
                f = FUNC_STOP_DATA;
            end else if (r < 93) begin
                f = FUNC_STOP_ACK;
            end else begin
                f = FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
            end
            // keep seqs in a narrow pool half the time so duplicates show up
            s = SEQ_W'($urandom_range(1) ? $urandom_range(255) : $urandom_range(7));
            // aim most data stops at a live data timer
            if (f == FUNC_STOP_DATA && $urandom_range(3) != 0) begin
                live_data = 0;
                for (i = 0; i < live_count; i++)
                    if (!timer_is_ack[i])
                        live_data++;
                if (live_data > 0) begin
                    pick = $urandom_range(live_data - 1);
                    for (i = 0; i < live_count; i++) begin
                        if (!timer_is_ack[i]) begin
                            if (pick == 0)
                                s = timer_seq[i];
                            pick--;
                        end
                    end
                end
            end
            send_op(f, s, 1'b0, QUIET);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, then random segments with the three
    // idling patterns and a fresh limit per segment.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int row;
        int k;
        int seg;
        int lim;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (row = 0; row < NUM_ROWS; row++) begin
            if (DIRECTED[row].what == ROW_LIMIT) begin
                write_limit(DIRECTED[row].arg);
            end else begin
                for (k = 0; k < int'(DIRECTED[row].reps); k++)
                    send_op(DIRECTED[row].func, DIRECTED[row].arg[SEQ_W-1:0] + k[SEQ_W-1:0],
                            DIRECTED[row].pin, DIRECTED[row].want);
            end
        end

        for (seg = 0; seg < NUM_SEGS; seg++) begin
            // receiver sparse then sender sparse, then both at full rate
            case (seg / 2)
                0: begin
                    send_idle_pct = 24;
                    recv_idle_pct = 76;
                end
                1: begin
                    send_idle_pct = 76;
                    recv_idle_pct = 24;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            lim = (seg == RANDOM_LIMIT_SEG) ? $urandom_range(60, 1) : SEG_LIMIT[seg];
            write_limit(lim[DELTA_W-1:0]);
            run_random(ITEMS_PER_SEG);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        // drain owed events; the watchdog bounds this wait
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("** retransmit_delta_timer_queue: PASSED **");
        end else begin
            $display("** retransmit_delta_timer_queue: FAILED **");
        end
        $finish;
    end

endmodule
